FILE: src/utf8d_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned REM_W    = 2;
    localparam int unsigned LEN_W    = 3;

    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;

    // Lead and continuation byte prefixes
    localparam logic [2:0] LEAD2_PFX = 3'b110;
    localparam logic [3:0] LEAD3_PFX = 4'b1110;
    localparam logic [4:0] LEAD4_PFX = 5'b11110;
    localparam logic [1:0] CONT_PFX  = 2'b10;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'b0011_1111;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEAD  = 3'd1,
        ST_MISSING   = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_SURROGATE = 3'd4,
        ST_RANGE     = 3'd5
    } utf8d_status_t;

    // One input item as held in the input register
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              last_byte;
    } utf8d_item_t;

    // One result item
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        utf8d_status_t   status;
        logic            string_end;
    } utf8d_result_t;

endpackage

FILE: src/utf8d_in_reg.sv
// Input register stage of the UTF-8 decoder.
// Depends on utf8d_pkg for the item type.
`timescale 1ns / 1ps

module utf8d_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  utf8d_pkg::utf8d_item_t in_item,
    input  logic                 advance,
    output logic                 hold_valid,
    output utf8d_pkg::utf8d_item_t hold_item
);
    import utf8d_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    utf8d_item_t item_reg;

    // Take a new item whenever the held one is empty or moves on
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

FILE: src/utf8d_decode.sv
// Sequence state and decode logic of the UTF-8 decoder.
// Depends on utf8d_pkg for types, prefixes and status codes.
`timescale 1ns / 1ps

module utf8d_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  utf8d_pkg::utf8d_item_t item,
    output logic                   emit,
    output utf8d_pkg::utf8d_result_t result
);
    import utf8d_pkg::*;

    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [CP_W-1:0]  pv_reg;
    logic [CP_W-1:0]  pv_next;

    logic [BYTE_W-1:0] b;
    logic [CP_W-1:0]   acc;
    logic [REM_W-1:0]  rem_dec;

    assign b       = item.in_byte;
    assign acc     = {pv_reg[CP_W-7:0], b[5:0]};
    assign rem_dec = rem_reg - 2'd1;

    // Decode one byte against the current sequence state
    always_comb
    begin
        rem_next          = rem_reg;
        len_next          = len_reg;
        pv_next           = pv_reg;
        emit              = 1'b0;
        result.code_point = '0;
        result.status     = ST_OK;
        result.string_end = item.last_byte;
        if (rem_reg == '0)
        begin
            priority if (b[7] == 1'b0)
            begin
                emit              = 1'b1;
                result.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
            end
            else if (b[7:5] == LEAD2_PFX || b[7:4] == LEAD3_PFX || b[7:3] == LEAD4_PFX)
            begin
                if (item.last_byte)
                begin
                    emit          = 1'b1;
                    result.status = ST_TRUNC;
                end
                else if (b[7:5] == LEAD2_PFX)
                begin
                    rem_next = 2'd1;
                    len_next = 3'd2;
                    pv_next  = {{(CP_W-5){1'b0}}, b[4:0]};
                end
                else if (b[7:4] == LEAD3_PFX)
                begin
                    rem_next = 2'd2;
                    len_next = 3'd3;
                    pv_next  = {{(CP_W-4){1'b0}}, b[3:0]};
                end
                else
                begin
                    rem_next = 2'd3;
                    len_next = 3'd4;
                    pv_next  = {{(CP_W-3){1'b0}}, b[2:0]};
                end
            end
            else
            begin
                emit          = 1'b1;
                result.status = ST_BAD_LEAD;
            end
        end
        else if (b[7:6] != CONT_PFX)
        begin
            // Drop the byte and return to idle
            emit          = 1'b1;
            result.status = ST_MISSING;
            rem_next      = '0;
            len_next      = '0;
            pv_next       = '0;
        end
        else if (rem_dec != '0)
        begin
            if (item.last_byte)
            begin
                emit          = 1'b1;
                result.status = ST_TRUNC;
                rem_next      = '0;
                len_next      = '0;
                pv_next       = '0;
            end
            else
            begin
                rem_next = rem_dec;
                pv_next  = acc;
            end
        end
        else
        begin
            // Sequence complete: check value and go idle
            emit     = 1'b1;
            rem_next = '0;
            len_next = '0;
            pv_next  = '0;
            priority if (len_reg == 3'd3 && acc >= SURR_LO && acc <= SURR_HI)
            begin
                result.status = ST_SURROGATE;
            end
            else if (len_reg == 3'd4 && acc > CP_MAX)
            begin
                result.status = ST_RANGE;
            end
            else
            begin
                result.code_point = acc;
            end
        end
    end

    // Advance state on each consumed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            len_reg <= '0;
            pv_reg  <= '0;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            len_reg <= len_next;
            pv_reg  <= pv_next;
        end
    end

    a_idle_len: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg == '0 |-> len_reg == '0)
        else $error("sequence length set while idle");

    a_len_cover: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != '0 |-> len_reg > {1'b0, rem_reg})
        else $error("sequence length does not cover remaining bytes");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit && result.status != ST_OK |-> result.code_point == '0)
        else $error("error result with nonzero code point");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit |=> rem_reg == '0)
        else $error("state not idle after a result");

endmodule

FILE: src/utf8d_out_reg.sv
// Result register stage of the UTF-8 decoder.
// Depends on utf8d_pkg for the result type.
`timescale 1ns / 1ps

module utf8d_out_reg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic                     load_valid,
    input  utf8d_pkg::utf8d_result_t load_result,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic                     advance,
    output utf8d_pkg::utf8d_result_t out_result
);
    import utf8d_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    utf8d_result_t result_reg;

    // Move on when the register is empty or its item is being taken
    assign advance = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = load && load_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (advance && load && load_valid)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

FILE: src/utf8_validating_decoder.sv
// Input accept to result valid passes the input register, then the result register.
// Throughput: one byte item per cycle unless the output stalls; the result register and
// input register refill in the cycle their item moves on; a stall holds one item in each.
// A byte that finishes a sequence or hits an error gives one result; others give none.
// Reset (rst_n low, asynchronous) empties both registers and returns the decoder to idle.
// Top level of the UTF-8 validating decoder; depends on utf8d_pkg and the utf8d_* stages.
`timescale 1ns / 1ps

module utf8_validating_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast    // string_end
);
    import utf8d_pkg::*;

    utf8d_item_t   in_item;
    utf8d_item_t   hold_item;
    logic          hold_valid;
    logic          advance;
    logic          step;
    logic          emit;
    utf8d_result_t dec_result;
    utf8d_result_t out_result;

    assign in_item.in_byte   = s_tdata;
    assign in_item.last_byte = s_tlast;

    utf8d_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    // Consume the held item when the result side can take it
    assign step = hold_valid && advance;

    utf8d_decode u_dec (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (hold_item),
        .emit   (emit),
        .result (dec_result)
    );

    utf8d_out_reg u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (hold_valid),
        .load_valid  (emit),
        .load_result (dec_result),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .advance     (advance),
        .out_result  (out_result)
    );

    assign m_tdata = {{(24-CP_W){1'b0}}, out_result.code_point};
    assign m_tuser = out_result.status;
    assign m_tlast = out_result.string_end;

endmodule
